// ===== sv/slfo_pkg.sv =====
// Shared constants, register indexes and command codes of the step LFO.
package slfo_pkg;

    // Default sizes of the step table
    localparam int MAX_STEPS_DEF  = 64;
    localparam int LEVEL_BITS_DEF = 16;

    // Fixed field widths
    localparam int MODE_W     = 2;
    localparam int STEP_IDX_W = 6;
    localparam int INC_W      = 26;
    localparam int NS_W       = 7;
    localparam int SM_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;

    // Phase format: integer steps above PHASE_FRAC fraction bits
    localparam int PHASE_FRAC = 24;
    localparam int MU_BITS    = 15;

    // Pattern length floor
    localparam int MIN_STEPS = 2;

    // Reset ramp over the first steps, rounded half away from zero
    localparam int RAMP_STEPS = 16;
    localparam int RAMP_DIV   = RAMP_STEPS - 1;
    localparam int RAMP_HALF  = RAMP_DIV / 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 2'd2;

    // Register reset values
    localparam logic [INC_W-1:0] PHASE_INC_RST = 26'd48697;
    localparam logic [NS_W-1:0]  NUM_STEPS_RST = 7'd16;
    localparam logic [SM_W-1:0]  SMOOTHING_RST = 2'd0;

    // Input commands
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

    // Smoothing selections; any other code means cubic
    localparam logic [SM_W-1:0] SMOOTH_HOLD   = 2'd0;
    localparam logic [SM_W-1:0] SMOOTH_LINEAR = 2'd1;

endpackage

// ===== sv/slfo_step_mem.sv =====
// Step level memory: one write port, one registered read port, reset ramp via valid bits.
module slfo_step_mem #(
    parameter int MAX_STEPS  = slfo_pkg::MAX_STEPS_DEF,
    parameter int LEVEL_BITS = slfo_pkg::LEVEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_STEPS)-1:0]  wr_addr,
    input  logic signed [LEVEL_BITS-1:0]  wr_data,
    input  logic [$clog2(MAX_STEPS)-1:0]  rd_addr,
    output logic signed [LEVEL_BITS-1:0]  rd_data
);
    import slfo_pkg::*;

    localparam int RAMP_SEL_W = $clog2(RAMP_STEPS);

    // Build the reset ramp from minus full scale to plus full scale
    function automatic logic [RAMP_STEPS*LEVEL_BITS-1:0] build_ramp();
        logic [RAMP_STEPS*LEVEL_BITS-1:0] tbl;
        int num;
        int lvl;
        int lmax;
        lmax = (1 << (LEVEL_BITS - 1)) - 1;
        tbl  = '0;
        for (int i = 0; i < RAMP_STEPS; i++)
        begin
            num = (2 * i - (RAMP_STEPS - 1)) * lmax;
            if (num >= 0)
            begin
                lvl = (num + RAMP_HALF) / RAMP_DIV;
            end
            else
            begin
                lvl = -((-num + RAMP_HALF) / RAMP_DIV);
            end
            tbl[i*LEVEL_BITS +: LEVEL_BITS] = LEVEL_BITS'(lvl);
        end
        return tbl;
    endfunction

    localparam logic [RAMP_STEPS*LEVEL_BITS-1:0] RAMP_TABLE = build_ramp();

    logic [LEVEL_BITS-1:0] step_mem [MAX_STEPS];
    logic [MAX_STEPS-1:0]  valid_reg;
    logic [LEVEL_BITS-1:0] mem_rd_reg;
    logic [LEVEL_BITS-1:0] ramp_rd_reg;
    logic                  valid_rd_reg;
    logic [RAMP_SEL_W-1:0] ramp_sel;
    logic [LEVEL_BITS-1:0] ramp_lvl;

    // Look up the reset level of the addressed step
    assign ramp_sel = RAMP_SEL_W'(rd_addr);
    assign ramp_lvl = (rd_addr < RAMP_STEPS) ? RAMP_TABLE[ramp_sel*LEVEL_BITS +: LEVEL_BITS]
                                             : '0;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            step_mem[wr_addr] <= wr_data;
        end
        mem_rd_reg  <= step_mem[rd_addr];
        ramp_rd_reg <= ramp_lvl;
    end

    // Mark written entries; reset makes every entry read as its ramp level, zero past the ramp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            valid_rd_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = valid_rd_reg ? $signed(mem_rd_reg) : $signed(ramp_rd_reg);

endmodule

// ===== sv/step_lfo_interpolator.sv =====
// Step LFO top level: phase wrap, table reads and hold, linear or cubic interpolation.
// Sequence: a tick gives its sample after the phase wrap, the table reads and the interpolation;
//   write and phase reset items finish in the cycle of their transfer.
// Throughput: one item at a time; a tick occupies the block until its sample is taken, through the phase
//   wrap remainder (one bit a cycle), four reads of the single read port memory and the shared multiplier.
// Reset: phase and registers return to defaults at once; the table reads as the reset ramp.
module step_lfo_interpolator #(
    parameter int MAX_STEPS  = slfo_pkg::MAX_STEPS_DEF,
    parameter int LEVEL_BITS = slfo_pkg::LEVEL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slfo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slfo_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [slfo_pkg::MODE_W-1:0]       mode,
    input  logic [slfo_pkg::STEP_IDX_W-1:0]   step_index,
    input  logic signed [LEVEL_BITS-1:0]      step_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [LEVEL_BITS+1:0]      sample_out
);
    import slfo_pkg::*;

    localparam int IDX_W   = $clog2(MAX_STEPS);
    localparam int N_W     = $clog2(MAX_STEPS + 1);
    localparam int PHASE_W = IDX_W + PHASE_FRAC;
    localparam int SUM_W   = ((PHASE_W > INC_W) ? PHASE_W : INC_W) + 1;
    localparam int SINT_W  = SUM_W - PHASE_FRAC;
    localparam int CNT_W   = $clog2(SINT_W);
    localparam int B_W     = LEVEL_BITS + 4;
    localparam int ACC_W   = LEVEL_BITS + 21;
    localparam int PROD_W  = ACC_W + MU_BITS + 1;
    localparam int OUT_W   = LEVEL_BITS + 2;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MIN     = LEVEL_BITS'(1) << (LEVEL_BITS - 1);
    localparam logic [LEVEL_BITS-1:0] LEVEL_NEG_MAX = LEVEL_MIN | LEVEL_BITS'(1);
    localparam logic signed [PROD_W-1:0] RND_MU     = PROD_W'(1) << (MU_BITS - 1);
    localparam logic signed [PROD_W-1:0] RND_FINAL  = PROD_W'(1) << (2 * MU_BITS);

    // Sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MOD  = 5'd1;
    localparam logic [4:0] S_RD0  = 5'd2;
    localparam logic [4:0] S_RD1  = 5'd3;
    localparam logic [4:0] S_RD2  = 5'd4;
    localparam logic [4:0] S_RD3  = 5'd5;
    localparam logic [4:0] S_RD4  = 5'd6;
    localparam logic [4:0] S_RD5  = 5'd7;
    localparam logic [4:0] S_COEF = 5'd8;
    localparam logic [4:0] S_MUL1 = 5'd9;
    localparam logic [4:0] S_ADD1 = 5'd10;
    localparam logic [4:0] S_MUL2 = 5'd11;
    localparam logic [4:0] S_ADD2 = 5'd12;
    localparam logic [4:0] S_MUL3 = 5'd13;
    localparam logic [4:0] S_ADD3 = 5'd14;
    localparam logic [4:0] S_DONE = 5'd15;

    logic [4:0]             state_reg;
    logic [INC_W-1:0]       phase_inc_reg;
    logic [NS_W-1:0]        num_steps_reg;
    logic [SM_W-1:0]        smooth_reg;
    logic [PHASE_W-1:0]     phase_reg;
    logic                   out_valid_reg;

    logic [SINT_W-1:0]      sum_int_reg;
    logic [PHASE_FRAC-1:0]  frac_reg;
    logic [IDX_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic signed [LEVEL_BITS-1:0] y0_reg;
    logic signed [LEVEL_BITS-1:0] y1_reg;
    logic signed [LEVEL_BITS-1:0] y2_reg;
    logic signed [LEVEL_BITS-1:0] y3_reg;
    logic signed [B_W-1:0]  b1_reg;
    logic signed [B_W-1:0]  b2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OUT_W-1:0] res_reg;
    logic signed [OUT_W-1:0] sample_reg;

    logic                   in_fire;
    logic                   out_load;
    logic [N_W-1:0]         pat_len;
    logic [SUM_W-1:0]       sum_c;
    logic [IDX_W:0]         div_t;
    logic [IDX_W-1:0]       div_rem;
    logic [IDX_W-1:0]       k0;
    logic [IDX_W-1:0]       k1;
    logic [IDX_W-1:0]       km;
    logic [IDX_W-1:0]       k2;
    logic [MU_BITS-1:0]     mu;
    logic signed [B_W-1:0]  yw0;
    logic signed [B_W-1:0]  yw1;
    logic signed [B_W-1:0]  yw2;
    logic signed [B_W-1:0]  yw3;
    logic signed [B_W-1:0]  b0_c;
    logic signed [B_W-1:0]  b1_c;
    logic signed [B_W-1:0]  b2_c;
    logic signed [PROD_W-1:0] r15_w;
    logic signed [PROD_W-1:0] r31_w;

    logic                   mem_wr_en;
    logic [IDX_W-1:0]       mem_wr_addr;
    logic signed [LEVEL_BITS-1:0] mem_wr_data;
    logic [IDX_W-1:0]       mem_rd_addr;
    logic signed [LEVEL_BITS-1:0] mem_rd_data;

    // Handshakes
    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= PHASE_INC_RST;
            num_steps_reg <= NUM_STEPS_RST;
            smooth_reg    <= SMOOTHING_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PHASE_INC: phase_inc_reg <= cfg_data[INC_W-1:0];
                CFG_NUM_STEPS: num_steps_reg <= cfg_data[NS_W-1:0];
                CFG_SMOOTHING: smooth_reg    <= cfg_data[SM_W-1:0];
                default:       ;
            endcase
        end
    end

    // Clamp the pattern length
    always_comb
    begin
        if (num_steps_reg < NS_W'(MIN_STEPS))
        begin
            pat_len = N_W'(MIN_STEPS);
        end
        else if (int'(num_steps_reg) > MAX_STEPS)
        begin
            pat_len = N_W'(MAX_STEPS);
        end
        else
        begin
            pat_len = N_W'(num_steps_reg);
        end
    end

    // Advance the phase; one restoring remainder step on the integer part per cycle
    assign sum_c   = SUM_W'(phase_reg) + SUM_W'(phase_inc_reg);
    assign div_t   = {rem_reg, sum_int_reg[SINT_W-1]};
    assign div_rem = (div_t >= (IDX_W+1)'(pat_len)) ? IDX_W'(div_t - (IDX_W+1)'(pat_len))
                                                    : IDX_W'(div_t);

    // Current step, its circular neighbours and the weight
    assign k0 = phase_reg[PHASE_W-1:PHASE_FRAC];
    assign mu = phase_reg[PHASE_FRAC-1 -: MU_BITS];
    assign k1 = ((N_W'(k0) + N_W'(1)) == pat_len) ? '0 : IDX_W'(N_W'(k0) + N_W'(1));
    assign km = (k0 == '0) ? IDX_W'(pat_len - N_W'(1)) : IDX_W'(k0 - IDX_W'(1));
    assign k2 = ((N_W'(k1) + N_W'(1)) == pat_len) ? '0 : IDX_W'(N_W'(k1) + N_W'(1));

    // Select the read address for each read slot; data returns in the next slot
    always_comb
    begin
        unique case (state_reg)
            S_RD1:   mem_rd_addr = k0;
            S_RD2:   mem_rd_addr = k1;
            S_RD3:   mem_rd_addr = km;
            default: mem_rd_addr = k2;
        endcase
    end

    // Store a clamped level when the step lies inside the pattern
    assign mem_wr_en   = in_fire && (mode == MODE_WRITE) && (step_index < pat_len);
    assign mem_wr_addr = IDX_W'(step_index);
    assign mem_wr_data = (step_value == LEVEL_MIN) ? $signed(LEVEL_NEG_MAX) : step_value;

    slfo_step_mem #(
        .MAX_STEPS  (MAX_STEPS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_step_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Doubled cubic coefficients
    assign yw0  = B_W'(y0_reg);
    assign yw1  = B_W'(y1_reg);
    assign yw2  = B_W'(y2_reg);
    assign yw3  = B_W'(y3_reg);
    assign b0_c = -yw0 + (yw1 <<< 1) + yw1 - (yw2 <<< 1) - yw2 + yw3;
    assign b1_c = (yw0 <<< 1) - (yw1 <<< 2) - yw1 + (yw2 <<< 2) - yw3;
    assign b2_c = yw2 - yw0;

    // Round the product to nearest, halves upward
    assign r15_w = (prod_reg + RND_MU) >>> MU_BITS;
    assign r31_w = (prod_reg + RND_FINAL) >>> (2 * MU_BITS + 1);

    // Sequence control, phase and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (mode)
                            MODE_TICK:  state_reg <= S_MOD;
                            MODE_RESET: phase_reg <= '0;
                            default:    ;
                        endcase
                    end
                end
                S_MOD:
                begin
                    if (cnt_reg == '0)
                    begin
                        phase_reg <= {div_rem, frac_reg};
                        state_reg <= S_RD0;
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1: state_reg <= S_RD2;
                S_RD2: state_reg <= S_RD3;
                S_RD3: state_reg <= S_RD4;
                S_RD4: state_reg <= S_RD5;
                S_RD5: state_reg <= S_COEF;
                S_COEF:
                begin
                    state_reg <= (smooth_reg == SMOOTH_HOLD) ? S_DONE : S_MUL1;
                end
                S_MUL1: state_reg <= S_ADD1;
                S_ADD1:
                begin
                    state_reg <= (smooth_reg == SMOOTH_LINEAR) ? S_DONE : S_MUL2;
                end
                S_MUL2: state_reg <= S_ADD2;
                S_ADD2: state_reg <= S_MUL3;
                S_MUL3: state_reg <= S_ADD3;
                S_ADD3: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            // Hold a waiting sample until its transfer
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (mode == MODE_TICK))
                begin
                    sum_int_reg <= sum_c[SUM_W-1:PHASE_FRAC];
                    frac_reg    <= sum_c[PHASE_FRAC-1:0];
                    rem_reg     <= '0;
                    cnt_reg     <= CNT_W'(SINT_W - 1);
                end
            end
            S_MOD:
            begin
                rem_reg     <= div_rem;
                sum_int_reg <= sum_int_reg << 1;
                cnt_reg     <= cnt_reg - CNT_W'(1);
            end
            S_RD2: y1_reg <= mem_rd_data;
            S_RD3: y2_reg <= mem_rd_data;
            S_RD4: y0_reg <= mem_rd_data;
            S_RD5: y3_reg <= mem_rd_data;
            S_COEF:
            begin
                b1_reg <= b1_c;
                b2_reg <= b2_c;
                unique case (smooth_reg)
                    SMOOTH_HOLD:   res_reg <= OUT_W'(y1_reg);
                    SMOOTH_LINEAR: acc_reg <= ACC_W'(yw2 - yw1);
                    default:       acc_reg <= ACC_W'(b0_c);
                endcase
            end
            S_MUL1, S_MUL2, S_MUL3:
            begin
                prod_reg <= acc_reg * $signed({1'b0, mu});
            end
            S_ADD1:
            begin
                if (smooth_reg == SMOOTH_LINEAR)
                begin
                    res_reg <= OUT_W'(r15_w + PROD_W'(y1_reg));
                end
                else
                begin
                    acc_reg <= ACC_W'(prod_reg + (PROD_W'(b1_reg) <<< MU_BITS));
                end
            end
            S_ADD2:
            begin
                acc_reg <= ACC_W'(r15_w + (PROD_W'(b2_reg) <<< MU_BITS));
            end
            S_ADD3:
            begin
                res_reg <= OUT_W'(r31_w + PROD_W'(y1_reg));
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    sample_reg <= res_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== dv/testbench.sv =====
// Testbench for the step LFO: directed table, then randomized items checked against a predictor.
`timescale 1ns / 1ps

module testbench;
    import slfo_pkg::*;

    localparam int     LVL_W          = LEVEL_BITS_DEF;
    localparam int     OUT_W          = LEVEL_BITS_DEF + 2;
    localparam longint LEVEL_MAX      = (longint'(1) << (LVL_W - 1)) - 1;
    localparam int     SETTLE_CYCLES  = 25;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SEGMENTS       = 7;
    localparam int     SEG_ITEMS      = 50;

    // Codes that the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_UNUSED      = 2'd3;
    localparam logic [SM_W-1:0]   SMOOTH_CUBIC     = 2'd2;
    localparam logic [SM_W-1:0]   SMOOTH_CUBIC_ALT = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        logic [MODE_W-1:0]       cmd;
        logic [STEP_IDX_W-1:0]   idx;
        logic [LVL_W-1:0]        level;
        logic                    typed;
        logic [OUT_W-1:0]        want;
    } stim_row_t;

    localparam int DIR_ROWS = 32;

    // Directed rows; a typed expectation is given only where it is obvious
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b1, -18'sd32767},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_WRITE, 6'd0, 16'h8000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_WRITE, 6'd1, 16'h7FFF, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_WRITE, 6'd63, 16'h1234, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_UNUSED, 6'd63, 16'hFFFF, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_RESET, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b1, -18'sd32767},
        '{ROW_CFG, CFG_PHASE_INC, 26'd33554432, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_CFG, CFG_SMOOTHING, 26'(SMOOTH_LINEAR), MODE_TICK, 6'd0, 16'h0, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_CFG, CFG_SMOOTHING, 26'(SMOOTH_CUBIC), MODE_TICK, 6'd0, 16'h0, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_CFG, CFG_SMOOTHING, 26'(SMOOTH_CUBIC_ALT), MODE_TICK, 6'd0, 16'h0, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_CFG, CFG_NUM_STEPS, 26'd64, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_WRITE, 6'd63, 16'h7FFF, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_WRITE, 6'd62, 16'h8000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_CFG, CFG_NUM_STEPS, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_CFG, CFG_NUM_STEPS, 26'd127, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_CFG, CFG_PHASE_INC, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_RESET, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_WRITE, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_CFG, CFG_PHASE_INC, 26'h3FFFFFF, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0},
        '{ROW_ITEM, 2'd0, 26'd0, MODE_TICK, 6'd0, 16'h0000, 1'b0, 18'd0}
    };

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          cfg_valid  = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index  = '0;
    logic [CFG_DATA_W-1:0]         cfg_data   = '0;
    logic                          in_valid   = 1'b0;
    logic                          in_ready;
    logic [MODE_W-1:0]             mode       = '0;
    logic [STEP_IDX_W-1:0]         step_index = '0;
    logic signed [LVL_W-1:0]       step_value = '0;
    logic                          out_valid;
    logic                          out_ready  = 1'b0;
    logic signed [OUT_W-1:0]       sample_out;

    // Predictor state: phase in Q6.24 steps, level table, registers
    longint unsigned               phase_q;
    longint                        level_tab [MAX_STEPS_DEF];
    logic [INC_W-1:0]              inc_reg;
    logic [NS_W-1:0]               nsteps_reg;
    logic [SM_W-1:0]               smooth_reg;

    logic signed [OUT_W-1:0]       expected_samples [$];
    int                            fail_count = 0;
    int                            send_idle_pct = 0;
    int                            recv_idle_pct = 0;
    int                            quiet_cycles  = 0;

    step_lfo_interpolator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .step_index (step_index),
        .step_value (step_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Round v / 2^s to nearest, halves toward plus infinity
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Advance the LFO by one item; return 1 and the sample for a tick
    function automatic bit lfo_step(input logic [MODE_W-1:0] m,
                                    input logic [STEP_IDX_W-1:0] idx,
                                    input logic signed [LVL_W-1:0] val,
                                    output logic signed [OUT_W-1:0] level_out);
        longint unsigned n, k0, k1, km, k2;
        longint mu, y0, y1, y2, y3, b0, b1, b2, h, lvl, res;
        n = 64'((nsteps_reg < MIN_STEPS) ? MIN_STEPS :
                (nsteps_reg > MAX_STEPS_DEF) ? MAX_STEPS_DEF : int'(nsteps_reg));
        level_out = '0;
        case (m)
            MODE_TICK:
            begin
                phase_q = (phase_q + inc_reg) % (n << PHASE_FRAC);
                k0 = phase_q >> PHASE_FRAC;
                k1 = (k0 + 1) % n;
                km = (k0 + n - 1) % n;
                k2 = (k1 + 1) % n;
                mu = longint'((phase_q & 64'hFF_FFFF) >> (PHASE_FRAC - MU_BITS));
                y1 = level_tab[k0];
                y2 = level_tab[k1];
                if (smooth_reg == SMOOTH_HOLD)
                    res = y1;
                else if (smooth_reg == SMOOTH_LINEAR)
                    res = y1 + round_shift((y2 - y1) * mu, MU_BITS);
                else
                begin
                    y0 = level_tab[km];
                    y3 = level_tab[k2];
                    b0 = -y0 + 3 * y1 - 3 * y2 + y3;
                    b1 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
                    b2 = y2 - y0;
                    h = b0 * mu + b1 * 32768;
                    h = h * mu + b2 * 1073741824;
                    h = round_shift(h, MU_BITS);
                    res = y1 + round_shift(h * mu, 2 * MU_BITS + 1);
                end
                level_out = res[OUT_W-1:0];
                return 1'b1;
            end
            MODE_WRITE:
            begin
                lvl = longint'(val);
                if (lvl > LEVEL_MAX)
                    lvl = LEVEL_MAX;
                if (lvl < -LEVEL_MAX)
                    lvl = -LEVEL_MAX;
                if (idx < n)
                    level_tab[idx] = lvl;
            end
            MODE_RESET:
                phase_q = 0;
            default:
                ;
        endcase
        return 1'b0;
    endfunction

    // Present one item, hold it until the transfer, then predict
    task automatic drive_item(input logic [MODE_W-1:0] m,
                              input logic [STEP_IDX_W-1:0] idx,
                              input logic [LVL_W-1:0] val,
                              input logic typed,
                              input logic [OUT_W-1:0] want);
        logic signed [OUT_W-1:0] predicted;
        bit                      has_sample;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        step_index <= idx;
        step_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        has_sample = lfo_step(m, idx, val, predicted);
        if (has_sample)
            expected_samples.push_back(typed ? want : predicted);
    endtask

    // Hold off the sender until every sample has come and the block is quiet
    task automatic drain_samples();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PHASE_INC: inc_reg    = val[INC_W-1:0];
            CFG_NUM_STEPS: nsteps_reg = val[NS_W-1:0];
            CFG_SMOOTHING: smooth_reg = val[SM_W-1:0];
            default:       ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Check each transferred sample and stall the receiver at random
    always @(posedge clk)
    begin : sample_sink
        logic signed [OUT_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
                report_mismatch($sformatf("sample_out %0d with no tick pending", sample_out));
            else
            begin
                want = expected_samples.pop_front();
                if (sample_out !== want)
                    report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                              sample_out, want));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run when no channel has moved a transfer for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                      i, ph, seg, k, sel;
        logic [MODE_W-1:0]       m;
        logic [STEP_IDX_W-1:0]   idx;
        logic [LVL_W-1:0]        val;
        logic [CFG_DATA_W-1:0]   inc_val;
        logic [CFG_DATA_W-1:0]   ns_val;

        // Reset ramp over the first steps, half away from zero
        for (i = 0; i < MAX_STEPS_DEF; i++)
        begin
            level_tab[i] = 0;
            if (i < RAMP_STEPS)
            begin
                k = int'((2 * i - RAMP_DIV) * LEVEL_MAX);
                level_tab[i] = longint'((k >= 0) ? (k + RAMP_HALF) / RAMP_DIV
                                                 : -((-k + RAMP_HALF) / RAMP_DIV));
            end
        end
        phase_q    = 0;
        inc_reg    = PHASE_INC_RST;
        nsteps_reg = NUM_STEPS_RST;
        smooth_reg = SMOOTHING_RST;

        send_idle_pct = 9;
        recv_idle_pct = 54;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                drain_samples();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                drive_item(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].level,
                           dir_rows[i].typed, dir_rows[i].want);
        end

        // Random segments under three idling profiles
        for (ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 9 : 0;
            for (seg = 0; seg < SEGMENTS; seg++)
            begin
                drain_samples();
                case ($urandom_range(0, 5))
                    0:       inc_val = '0;
                    1:       inc_val = 26'd33554432;
                    2:       inc_val = CFG_DATA_W'($urandom_range(1, 2000000));
                    3:       inc_val = CFG_DATA_W'($urandom_range(0, 33554432));
                    4:       inc_val = 26'd1 << PHASE_FRAC;
                    default: inc_val = CFG_DATA_W'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0:       ns_val = CFG_DATA_W'(MIN_STEPS);
                    1:       ns_val = CFG_DATA_W'(MAX_STEPS_DEF);
                    2:       ns_val = CFG_DATA_W'($urandom_range(0, 127));
                    default: ns_val = CFG_DATA_W'($urandom_range(MIN_STEPS, MAX_STEPS_DEF));
                endcase
                write_reg(CFG_PHASE_INC, inc_val);
                write_reg(CFG_NUM_STEPS, ns_val);
                write_reg(CFG_SMOOTHING, CFG_DATA_W'($urandom_range(0, 3)));
                for (k = 0; k < SEG_ITEMS; k++)
                begin
                    sel = $urandom_range(0, 99);
                    m   = (sel < 60) ? MODE_TICK : (sel < 88) ? MODE_WRITE :
                          (sel < 95) ? MODE_RESET : MODE_UNUSED;
                    idx = STEP_IDX_W'($urandom_range(0, 63));
                    val = LVL_W'($urandom);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        case ($urandom_range(0, 3))
                            0:       val = 16'h8000;
                            1:       val = 16'h7FFF;
                            2:       val = 16'h8001;
                            default: val = 16'h0000;
                        endcase
                    end
                    drive_item(m, idx, val, 1'b0, '0);
                end
            end
        end

        // Wait out the remaining samples and report
        drain_samples();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/slfo_pkg.sv
sv/slfo_step_mem.sv
sv/step_lfo_interpolator.sv
dv/testbench.sv
